// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define FCCE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define FCCE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/fcce_pkg.sv =====
// Package with the constants, codes and types of the FAT16 cluster chain engine.
package fcce_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  // Field widths.
  localparam int DATA_W  = 16;
  localparam int KIND_W  = 3;
  localparam int STAT_W  = 3;
  localparam int EIU_W   = 13;
  // Range compares hold any 16-bit cluster, the entry count and the table depth.
  localparam int LIM_W   = (EIU_W > DATA_W) ? EIU_W : DATA_W + 1;
  localparam int GUARD_W = DATA_W + 1;
  localparam int CFG_IW  = 1;
  localparam int CFG_DW  = 16;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ALLOC = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FREE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NEXT  = 3'd4;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 3'd1;
  localparam logic [STAT_W-1:0] ST_END     = 3'd2;
  localparam logic [STAT_W-1:0] ST_FREE    = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD     = 3'd4;
  localparam logic [STAT_W-1:0] ST_RANGE   = 3'd5;
  localparam logic [STAT_W-1:0] ST_LOOP    = 3'd6;

  // FAT16 entry codes.
  localparam logic [DATA_W-1:0] CODE_FREE    = 16'h0000;
  localparam logic [DATA_W-1:0] CODE_BAD     = 16'hFFF7;
  localparam logic [DATA_W-1:0] CODE_END_MIN = 16'hFFF8;
  localparam logic [DATA_W-1:0] CODE_END     = 16'hFFFF;
  localparam logic [DATA_W-1:0] FIRST_DATA   = 16'd2;
  localparam logic [DATA_W-1:0] SAT_MAX      = 16'hFFFF;
  localparam logic [GUARD_W-1:0] GUARD_EXTRA = 17'd8;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IW-1:0] CFG_ENTRIES = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_LIMIT   = 1'b1;
  localparam logic [EIU_W-1:0]  EIU_RST     = 13'd4096;
  localparam logic [DATA_W-1:0] CLIM_RST    = 16'd4094;

  // One accepted request.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] cluster;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] count;
  } req_t;

endpackage

// ===== rtl/fcce_req_if.sv =====
// Request channel interface: valid/ready handshake with the request fields.
interface fcce_req_if;
  logic                             valid;
  logic                             ready;
  logic [fcce_pkg::KIND_W-1:0]      kind;
  logic [fcce_pkg::DATA_W-1:0]      cluster;
  logic [fcce_pkg::DATA_W-1:0]      value;
  logic [fcce_pkg::DATA_W-1:0]      count;

  modport source (output valid, kind, cluster, value, count, input ready);
  modport sink   (input valid, kind, cluster, value, count, output ready);
endinterface

// ===== rtl/fcce_rsp_if.sv =====
// Result channel interface: valid/ready handshake with the result fields.
interface fcce_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [fcce_pkg::STAT_W-1:0]      status;
  logic [fcce_pkg::DATA_W-1:0]      cluster_out;
  logic [fcce_pkg::DATA_W-1:0]      freed_count;

  modport source (output valid, status, cluster_out, freed_count, input ready);
  modport sink   (input valid, status, cluster_out, freed_count, output ready);
endinterface

// ===== rtl/fcce_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
module fcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a same-address read returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/fat16_cluster_chain_engine_core.sv =====
// Top level: FAT16 allocation table in a RAM with a request sequencer around it.
// Load writes the entry in the decode state; read and next wait for the registered RAM data (not when out of range).
// Allocate scans the table at one entry per cycle (one RAM read port): a first pass counts free
// entries, a second pass links them; when space runs out it stops after the first pass.
// Free reads each chain link, then clears it, until the chain ends or the loop guard trips.
// One request at a time; synchronous reset restores the control registers, the table persists.
module fat16_cluster_chain_engine_core (
  input  logic                          clk,
  input  logic                          rst_n,
  fcce_req_if.sink                      in_req,
  fcce_rsp_if.source                    out_rsp,
  input  logic                          cfg_we,
  input  logic [fcce_pkg::CFG_IW-1:0]   cfg_idx,
  input  logic [fcce_pkg::CFG_DW-1:0]   cfg_wdata
);
  import fcce_pkg::*;

  // Sequencer state codes.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_RDW  = 4'd2;
  localparam logic [3:0] S_NXW  = 4'd3;
  localparam logic [3:0] S_CNT  = 4'd4;
  localparam logic [3:0] S_LNK  = 4'd5;
  localparam logic [3:0] S_FIN  = 4'd6;
  localparam logic [3:0] S_WRD  = 4'd7;
  localparam logic [3:0] S_WWT  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]         state_r, state_nxt;
  req_t               req_r, req_nxt;
  logic [EIU_W-1:0]   eiu_r, eiu_nxt;
  logic [DATA_W-1:0]  clim_r, clim_nxt;
  logic [LIM_W-1:0]   scan_addr_r, scan_addr_nxt;
  logic               pend_r, pend_nxt;
  logic [ADDR_W-1:0]  pend_addr_r, pend_addr_nxt;
  logic [DATA_W-1:0]  found_r, found_nxt;
  logic [ADDR_W-1:0]  prev_r, prev_nxt;
  logic [ADDR_W-1:0]  first_r, first_nxt;
  logic [DATA_W-1:0]  cur_r, cur_nxt;
  logic [GUARD_W-1:0] steps_r, steps_nxt;
  logic [DATA_W-1:0]  step_cnt_r, step_cnt_nxt;
  logic [DATA_W-1:0]  tail_r, tail_nxt;
  logic [STAT_W-1:0]  res_status_r, res_status_nxt;
  logic [DATA_W-1:0]  res_cluster_r, res_cluster_nxt;
  logic [DATA_W-1:0]  res_freed_r, res_freed_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [DATA_W-1:0]  out_cluster_r, out_cluster_nxt;
  logic [DATA_W-1:0]  out_freed_r, out_freed_nxt;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [DATA_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [DATA_W-1:0]  mem_rdata;

  logic [LIM_W-1:0]   eiu_ext;
  logic [LIM_W-1:0]   lim;
  logic [GUARD_W-1:0] guard;
  logic [LIM_W-1:0]   req_cl_ext;
  logic [LIM_W-1:0]   cur_ext;
  logic [LIM_W-1:0]   rd_ext;
  logic               req_in_range;
  logic               scan_more;
  logic               hit_free;
  logic [DATA_W-1:0]  found_inc;
  logic [DATA_W-1:0]  sc_new;
  logic [STAT_W-1:0]  nx_status;
  logic [GUARD_W-1:0] steps_inc;
  logic               walk_go;
  logic               pub;

  // Table storage.
  fcce_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Handshake outputs.
  assign in_req.ready        = (state_r == S_IDLE);
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.cluster_out = out_cluster_r;
  assign out_rsp.freed_count = out_freed_r;

  // Effective table limit, loop guard and common comparisons.
  assign eiu_ext      = LIM_W'(eiu_r);
  assign lim          = (eiu_ext > LIM_W'(TABLE_DEPTH)) ? LIM_W'(TABLE_DEPTH) : eiu_ext;
  assign guard        = GUARD_W'(clim_r) + GUARD_EXTRA;
  assign req_cl_ext   = LIM_W'(req_r.cluster);
  assign cur_ext      = LIM_W'(cur_r);
  assign rd_ext       = LIM_W'(mem_rdata);
  assign req_in_range = (req_cl_ext < lim);
  assign scan_more    = (scan_addr_r < lim);
  assign hit_free     = pend_r && (mem_rdata == CODE_FREE);
  assign found_inc    = found_r + 16'd1;
  assign steps_inc    = steps_r + GUARD_W'(1);
  assign walk_go      = (cur_r >= FIRST_DATA) && (cur_ext < lim) && (cur_r < CODE_END_MIN);
  assign pub          = (state_r == S_DONE) && (!out_valid_r || out_rsp.ready);

  // Step count of a next request: continue the previous walk or start a new one.
  always_comb begin
    if ((step_cnt_r != '0) && (req_r.cluster == tail_r)) begin
      sc_new = (step_cnt_r == SAT_MAX) ? step_cnt_r : step_cnt_r + 16'd1;
    end else begin
      sc_new = 16'd1;
    end
  end

  // Classification of the entry returned to a next request.
  always_comb begin
    if (mem_rdata == CODE_FREE) begin
      nx_status = ST_FREE;
    end else if (mem_rdata == CODE_BAD) begin
      nx_status = ST_BAD;
    end else if (mem_rdata >= CODE_END_MIN) begin
      nx_status = ST_END;
    end else if ((mem_rdata < FIRST_DATA) || (rd_ext >= lim)) begin
      nx_status = ST_RANGE;
    end else if (GUARD_W'(sc_new) > guard) begin
      nx_status = ST_LOOP;
    end else begin
      nx_status = ST_OK;
    end
  end

  // Sequencer: next-state logic and RAM port control.
  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    eiu_nxt         = eiu_r;
    clim_nxt        = clim_r;
    scan_addr_nxt   = scan_addr_r;
    pend_nxt        = 1'b0;
    pend_addr_nxt   = pend_addr_r;
    found_nxt       = found_r;
    prev_nxt        = prev_r;
    first_nxt       = first_r;
    cur_nxt         = cur_r;
    steps_nxt       = steps_r;
    step_cnt_nxt    = step_cnt_r;
    tail_nxt        = tail_r;
    res_status_nxt  = res_status_r;
    res_cluster_nxt = res_cluster_r;
    res_freed_nxt   = res_freed_r;
    out_valid_nxt   = out_valid_r && !out_rsp.ready;
    out_status_nxt  = out_status_r;
    out_cluster_nxt = out_cluster_r;
    out_freed_nxt   = out_freed_r;
    mem_we          = 1'b0;
    mem_waddr       = req_r.cluster[ADDR_W-1:0];
    mem_wdata       = req_r.value;
    mem_re          = 1'b0;
    mem_raddr       = req_r.cluster[ADDR_W-1:0];

    // The user must write configuration only while the block is idle; the block does not enforce it.
    if (cfg_we) begin
      case (cfg_idx)
        CFG_ENTRIES: eiu_nxt  = cfg_wdata[EIU_W-1:0];
        CFG_LIMIT:   clim_nxt = cfg_wdata[DATA_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          req_nxt.kind    = in_req.kind;
          req_nxt.cluster = in_req.cluster;
          req_nxt.value   = in_req.value;
          req_nxt.count   = in_req.count;
          state_nxt       = S_DISP;
        end
      end

      // Decode the request and start its work.
      S_DISP: begin
        res_status_nxt  = ST_OK;
        res_cluster_nxt = '0;
        res_freed_nxt   = '0;
        if (req_r.kind != KIND_NEXT) begin
          step_cnt_nxt = '0;
        end
        case (req_r.kind)
          KIND_LOAD: begin
            if (req_in_range) begin
              mem_we = 1'b1;
            end else begin
              res_status_nxt = ST_RANGE;
            end
            state_nxt = S_DONE;
          end
          KIND_READ: begin
            if (req_in_range) begin
              mem_re    = 1'b1;
              state_nxt = S_RDW;
            end else begin
              res_status_nxt = ST_RANGE;
              state_nxt      = S_DONE;
            end
          end
          KIND_ALLOC: begin
            scan_addr_nxt = LIM_W'(FIRST_DATA);
            found_nxt     = '0;
            if (req_r.count == '0) begin
              res_status_nxt = ST_NOSPACE;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_CNT;
            end
          end
          KIND_FREE: begin
            cur_nxt   = req_r.cluster;
            steps_nxt = '0;
            state_nxt = S_WRD;
          end
          KIND_NEXT: begin
            if ((req_r.cluster < FIRST_DATA) || !req_in_range) begin
              res_status_nxt = ST_RANGE;
              step_cnt_nxt   = '0;
              state_nxt      = S_DONE;
            end else begin
              mem_re    = 1'b1;
              state_nxt = S_NXW;
            end
          end
          default: begin
            res_status_nxt = ST_RANGE;
            state_nxt      = S_DONE;
          end
        endcase
      end

      S_RDW: begin
        res_cluster_nxt = mem_rdata;
        state_nxt       = S_DONE;
      end

      S_NXW: begin
        res_cluster_nxt = mem_rdata;
        res_status_nxt  = nx_status;
        tail_nxt        = mem_rdata;
        step_cnt_nxt    = (nx_status == ST_OK) ? sc_new : '0;
        state_nxt       = S_DONE;
      end

      // First pass: count free entries until the request is covered or the scan runs out.
      S_CNT: begin
        if (scan_more) begin
          mem_re        = 1'b1;
          mem_raddr     = scan_addr_r[ADDR_W-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = scan_addr_r[ADDR_W-1:0];
          scan_addr_nxt = scan_addr_r + LIM_W'(1);
        end
        if (hit_free) begin
          found_nxt = found_inc;
          if (found_inc == req_r.count) begin
            scan_addr_nxt = LIM_W'(FIRST_DATA);
            pend_nxt      = 1'b0;
            found_nxt     = '0;
            state_nxt     = S_LNK;
          end
        end else if (!pend_r && !scan_more) begin
          res_status_nxt = ST_NOSPACE;
          state_nxt      = S_DONE;
        end
      end

      // Second pass: link each free entry found to the one before it.
      S_LNK: begin
        if (scan_more) begin
          mem_re        = 1'b1;
          mem_raddr     = scan_addr_r[ADDR_W-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = scan_addr_r[ADDR_W-1:0];
          scan_addr_nxt = scan_addr_r + LIM_W'(1);
        end
        if (hit_free) begin
          if (found_r == '0) begin
            first_nxt = pend_addr_r;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = prev_r;
            mem_wdata = DATA_W'(pend_addr_r);
          end
          prev_nxt  = pend_addr_r;
          found_nxt = found_inc;
          if (found_inc == req_r.count) begin
            pend_nxt  = 1'b0;
            state_nxt = S_FIN;
          end
        end
      end

      // Terminate the new chain with the end mark.
      S_FIN: begin
        mem_we          = 1'b1;
        mem_waddr       = prev_r;
        mem_wdata       = CODE_END;
        res_cluster_nxt = DATA_W'(first_r);
        state_nxt       = S_DONE;
      end

      // Free walk: fetch the current link if it is still part of the chain.
      S_WRD: begin
        mem_raddr = cur_r[ADDR_W-1:0];
        if (walk_go) begin
          mem_re    = 1'b1;
          state_nxt = S_WWT;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // Clear the visited entry and follow its link.
      S_WWT: begin
        mem_we        = 1'b1;
        mem_waddr     = cur_r[ADDR_W-1:0];
        mem_wdata     = CODE_FREE;
        res_freed_nxt = (res_freed_r == SAT_MAX) ? res_freed_r : res_freed_r + 16'd1;
        cur_nxt       = mem_rdata;
        steps_nxt     = steps_inc;
        if (steps_inc > guard) begin
          res_status_nxt = ST_LOOP;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_WRD;
        end
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (pub) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_cluster_nxt = res_cluster_r;
          out_freed_nxt   = res_freed_r;
          state_nxt       = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      eiu_r       <= EIU_RST;
      clim_r      <= CLIM_RST;
      pend_r      <= 1'b0;
      step_cnt_r  <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      eiu_r       <= eiu_nxt;
      clim_r      <= clim_nxt;
      pend_r      <= pend_nxt;
      step_cnt_r  <= step_cnt_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    scan_addr_r   <= scan_addr_nxt;
    pend_addr_r   <= pend_addr_nxt;
    found_r       <= found_nxt;
    prev_r        <= prev_nxt;
    first_r       <= first_nxt;
    cur_r         <= cur_nxt;
    steps_r       <= steps_nxt;
    res_status_r  <= res_status_nxt;
    res_cluster_r <= res_cluster_nxt;
    res_freed_r   <= res_freed_nxt;
    out_status_r  <= out_status_nxt;
    out_cluster_r <= out_cluster_nxt;
    out_freed_r   <= out_freed_nxt;
  end

endmodule

// ===== rtl/fcce_chk.sv =====
// Port-level checker for the cluster chain engine, bound to the top level.
`include "assert_macros.svh"

module fcce_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [fcce_pkg::STAT_W-1:0]   out_status,
  input logic [fcce_pkg::DATA_W-1:0]   out_cluster,
  input logic [fcce_pkg::DATA_W-1:0]   out_freed
);
  import fcce_pkg::*;

  // Reset empties the output register.
  `FCCE_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_valid, "result pending after reset")

  // One request at a time: after a transaction the request side closes.
  `FCCE_ASSERT(a_one_req, clk, rst_n, in_valid && in_ready |=> !in_ready, "second request taken while busy")

  // A stalled result holds its fields.
  `FCCE_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_cluster) && $stable(out_freed), "stalled result changed")

  // Only a free request reports released clusters, and it ends ok or with a loop.
  `FCCE_ASSERT(a_freed_status, clk, rst_n, out_valid && (out_freed != '0) |-> (out_status == ST_OK) || (out_status == ST_LOOP), "freed count with wrong status")

  // Status codes stay within the defined set.
  `FCCE_ASSERT(a_status_code, clk, rst_n, out_valid |-> out_status <= ST_LOOP, "undefined status code")

endmodule

bind fat16_cluster_chain_engine_core fcce_chk u_fcce_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_req.valid),
  .in_ready    (in_req.ready),
  .out_valid   (out_rsp.valid),
  .out_ready   (out_rsp.ready),
  .out_status  (out_rsp.status),
  .out_cluster (out_rsp.cluster_out),
  .out_freed   (out_rsp.freed_count)
);

// ===== dv/fcce_chain_checker.sv =====
// Checker for the FAT16 cluster chain engine: predicts every result and scores the DUT.
`timescale 1ns / 100ps
module fcce_chain_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  fcce_req_if                         req,
  fcce_rsp_if                         rsp,
  input  logic                        cfg_we,
  input  logic [fcce_pkg::CFG_IW-1:0] cfg_idx,
  input  logic [fcce_pkg::CFG_DW-1:0] cfg_wdata,
  output int                          fails,
  output int                          outstanding
);
  import fcce_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] cluster_out;
    logic [DATA_W-1:0] freed_count;
  } fat_rsp_t;

  // Shadow copy of the allocation table, the registers and the walk tracking.
  logic [DATA_W-1:0] fat_copy [TABLE_DEPTH];
  logic [EIU_W-1:0]  entries_cfg;
  logic [DATA_W-1:0] limit_cfg;
  logic [DATA_W-1:0] walk_tail;
  logic [DATA_W-1:0] walk_steps;
  fat_rsp_t          awaited_rsp [$];

  // Applies one request to the shadow state and returns the result it must produce.
  function automatic fat_rsp_t predict_fat_response(req_t r);
    fat_rsp_t res;
    int       lim;
    int       guard;
    int       cur;
    int       nxt;
    int       avail;
    int       taken;
    int       prev;
    int       steps;
    bit       tripped;
    res     = '0;
    lim     = (int'(entries_cfg) > TABLE_DEPTH) ? TABLE_DEPTH : int'(entries_cfg);
    guard   = int'(limit_cfg) + int'(GUARD_EXTRA);
    cur     = int'(r.cluster);
    tripped = 1'b0;
    if (r.kind != KIND_NEXT) walk_steps = '0;
    case (r.kind)
      KIND_LOAD: begin
        if (cur < lim) fat_copy[cur] = r.value;
        else res.status = ST_RANGE;
      end
      KIND_READ: begin
        if (cur < lim) res.cluster_out = fat_copy[cur];
        else res.status = ST_RANGE;
      end
      KIND_ALLOC: begin
        // First-fit from the first data cluster; nothing changes unless all fit.
        avail = 0;
        for (int i = int'(FIRST_DATA); i < lim; i++) begin
          if (fat_copy[i] == CODE_FREE) avail++;
        end
        if (r.count == '0 || avail < int'(r.count)) begin
          res.status = ST_NOSPACE;
        end else begin
          taken = 0;
          prev  = 0;
          for (int i = int'(FIRST_DATA); i < lim && taken < int'(r.count); i++) begin
            if (fat_copy[i] == CODE_FREE) begin
              if (taken == 0) res.cluster_out = DATA_W'(i);
              else fat_copy[prev] = DATA_W'(i);
              fat_copy[i] = CODE_END;
              prev = i;
              taken++;
            end
          end
          walk_tail = DATA_W'(prev);
        end
      end
      KIND_FREE: begin
        // Clear links until the chain leaves the data range, hits an end mark or trips the loop guard.
        steps = 0;
        while (!tripped && cur >= int'(FIRST_DATA) && cur < lim && cur < int'(CODE_END_MIN)) begin
          nxt           = int'(fat_copy[cur]);
          fat_copy[cur] = CODE_FREE;
          if (res.freed_count != SAT_MAX) res.freed_count++;
          cur = nxt;
          steps++;
          if (steps > guard) begin
            res.status = ST_LOOP;
            tripped    = 1'b1;
          end
        end
        walk_tail = DATA_W'(cur);
      end
      KIND_NEXT: begin
        if (cur < int'(FIRST_DATA) || cur >= lim) begin
          res.status = ST_RANGE;
          walk_steps = '0;
        end else begin
          nxt             = int'(fat_copy[cur]);
          res.cluster_out = DATA_W'(nxt);
          // A request at the cluster just returned continues the walk.
          if (walk_steps != '0 && cur == int'(walk_tail)) begin
            if (walk_steps != SAT_MAX) walk_steps++;
          end else begin
            walk_steps = 1;
          end
          if (nxt == int'(CODE_FREE)) res.status = ST_FREE;
          else if (nxt == int'(CODE_BAD)) res.status = ST_BAD;
          else if (nxt >= int'(CODE_END_MIN)) res.status = ST_END;
          else if (nxt < int'(FIRST_DATA) || nxt >= lim) res.status = ST_RANGE;
          else if (int'(walk_steps) > guard) res.status = ST_LOOP;
          walk_tail = DATA_W'(nxt);
          if (res.status != ST_OK) walk_steps = '0;
        end
      end
      default: begin
        res.status = ST_RANGE;
      end
    endcase
    return res;
  endfunction

  // Track register writes, predict on each request transaction, score each result.
  always @(posedge clk) begin
    req_t     r;
    fat_rsp_t want;
    fat_rsp_t got;
    if (!rst_n) begin
      entries_cfg = EIU_RST;
      limit_cfg   = CLIM_RST;
      walk_tail   = '0;
      walk_steps  = '0;
      awaited_rsp.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_ENTRIES) entries_cfg = cfg_wdata[EIU_W-1:0];
        else if (cfg_idx == CFG_LIMIT) limit_cfg = cfg_wdata;
      end
      if (rsp.valid && rsp.ready) begin
        got = {rsp.status, rsp.cluster_out, rsp.freed_count};
        if (awaited_rsp.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("[%0t] unexpected result: status %0d cluster_out 0x%04h freed_count %0d",
                     $time, got.status, got.cluster_out, got.freed_count);
          end
        end else begin
          want = awaited_rsp.pop_front();
          if (got.status !== want.status || got.cluster_out !== want.cluster_out ||
              got.freed_count !== want.freed_count) begin
            fails++;
            if (fails <= 10) begin
              $display("[%0t] result mismatch: status exp %0d got %0d, cluster_out exp 0x%04h",
                       $time, want.status, got.status, want.cluster_out);
              $display("    got 0x%04h, freed_count exp %0d got %0d",
                       got.cluster_out, want.freed_count, got.freed_count);
            end
          end
        end
      end
      if (req.valid && req.ready) begin
        r = {req.kind, req.cluster, req.value, req.count};
        awaited_rsp.push_back(predict_fat_response(r));
      end
    end
    outstanding = awaited_rsp.size();
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the FAT16 cluster chain engine: stimulus, back-pressure and verdict.
`timescale 1ns / 100ps
module tb;
  import fcce_pkg::*;

  // Kinds that the engine does not know.
  localparam logic [KIND_W-1:0] KIND_BAD_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_BAD_LAST  = 3'd7;

  // Entries cleared at the start; every traffic phase keeps its table limit within them.
  localparam int CLEAR_N = 512;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_idx;
  logic [CFG_DW-1:0] cfg_wdata;
  logic              rsp_take = 1'b0;
  int                fails;
  int                outstanding;

  // Stimulus bookkeeping.
  int                n_issued;
  int                n_sent;
  int                n_done;
  int                n_settings;
  int                lim_now;
  int                guard_now;
  int                walk_cap;
  bit                calm;
  logic [DATA_W-1:0] last_cluster;
  logic [STAT_W-1:0] last_status;
  int                kind_hits [8];
  int                status_hits [8];

  fcce_req_if req_ch ();
  fcce_rsp_if rsp_ch ();

  assign rsp_ch.ready = rsp_take;

  fat16_cluster_chain_engine_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_ch),
    .out_rsp   (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  fcce_chain_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .fails       (fails),
    .outstanding (outstanding)
  );

  // Clock generation.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result back-pressure: stall about 30 percent of cycles unless in a calm stretch.
  always @(posedge clk) begin
    rsp_take <= calm || ($urandom_range(99) >= 30);
  end

  // Count transactions on both channels and keep the last result for chain walks.
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready) n_sent <= n_sent + 1;
      if (rsp_ch.valid && rsp_ch.ready) begin
        n_done                      <= n_done + 1;
        last_cluster                <= rsp_ch.cluster_out;
        last_status                 <= rsp_ch.status;
        status_hits[rsp_ch.status]  <= status_hits[rsp_ch.status] + 1;
      end
    end
  end

  // Present one request after an optional random gap and wait for its transaction.
  task automatic send_req(input logic [KIND_W-1:0] k, input logic [DATA_W-1:0] c,
                          input logic [DATA_W-1:0] v, input logic [DATA_W-1:0] n);
    while (!calm && $urandom_range(99) < 30) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.kind    <= k;
    req_ch.cluster <= c;
    req_ch.value   <= v;
    req_ch.count   <= n;
    kind_hits[k]++;
    n_issued++;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Hold off the request side until every outstanding result has been taken.
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (n_done != n_sent) @(posedge clk);
  endtask

  // Write both registers while the engine is idle.
  task automatic set_phase(input int eiu, input int climit, input bit quiet);
    lim_now   = (eiu > TABLE_DEPTH) ? TABLE_DEPTH : eiu;
    guard_now = climit + int'(GUARD_EXTRA);
    walk_cap  = (guard_now + 4 < 40) ? guard_now + 4 : 40;
    calm      = quiet;
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_ENTRIES;
    cfg_wdata <= CFG_DW'(eiu);
    @(posedge clk);
    cfg_idx   <= CFG_LIMIT;
    cfg_wdata <= CFG_DW'(climit);
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [DATA_W-1:0] pick_cluster();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60 && lim_now > 2) return DATA_W'($urandom_range(lim_now - 1, 2));
    if (roll < 72) return DATA_W'($urandom_range(1, 0));
    if (roll < 85) return DATA_W'(lim_now + $urandom_range(3, 0));
    return DATA_W'($urandom);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 20) return CODE_FREE;
    if (roll < 30) return CODE_BAD;
    if (roll < 40) return DATA_W'($urandom_range(int'(CODE_END), int'(CODE_END_MIN)));
    if (roll < 70 && lim_now > 2) return DATA_W'($urandom_range(lim_now - 1, 2));
    return DATA_W'($urandom);
  endfunction

  function automatic logic [DATA_W-1:0] pick_count();
    int roll;
    int cap;
    roll = $urandom_range(99);
    cap  = (lim_now < 64) ? lim_now : 64;
    if (roll < 8) return '0;
    if (roll < 16) return DATA_W'($urandom);
    if (roll < 30) return DATA_W'($urandom_range(cap, 1));
    return DATA_W'($urandom_range(6, 1));
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) return KIND_LOAD;
    if (roll < 30) return KIND_READ;
    if (roll < 45) return KIND_ALLOC;
    if (roll < 60) return KIND_FREE;
    if (roll < 90) return KIND_NEXT;
    return KIND_W'($urandom_range(int'(KIND_BAD_LAST), int'(KIND_BAD_FIRST)));
  endfunction

  // Follow a chain link by link, each step waiting for the cluster it returns.
  task automatic walk_chain(input logic [DATA_W-1:0] start, input int steps_max);
    logic [DATA_W-1:0] cur;
    int                s;
    cur = start;
    s   = 0;
    do begin
      send_req(KIND_NEXT, cur, pick_value(), pick_count());
      settle();
      cur = last_cluster;
      s++;
    end while (s < steps_max && last_status == ST_OK);
  endtask

  // Allocate a chain, walk it and usually release it again from its head.
  task automatic chain_lifecycle();
    int                n;
    logic [DATA_W-1:0] head;
    n = ($urandom_range(99) < 25) ? $urandom_range(walk_cap, 1) : $urandom_range(6, 1);
    send_req(KIND_ALLOC, pick_cluster(), pick_value(), DATA_W'(n));
    settle();
    if (last_status == ST_OK) begin
      head = last_cluster;
      walk_chain(head, n + 2);
      if ($urandom_range(9) < 8) send_req(KIND_FREE, head, pick_value(), pick_count());
    end
  endtask

  // Link up to six clusters into a ring by loads, then walk it until the guard trips or the walk cap is hit.
  task automatic ring_walk();
    logic [DATA_W-1:0] ring [6];
    int                k;
    k = $urandom_range(6, 1);
    for (int i = 0; i < k; i++) ring[i] = DATA_W'($urandom_range(lim_now - 1, 2));
    for (int i = 0; i < k; i++) send_req(KIND_LOAD, ring[i], ring[(i + 1) % k], pick_count());
    walk_chain(ring[0], walk_cap);
    send_req(KIND_FREE, ring[0], pick_value(), pick_count());
  endtask

  // Random traffic for one register setting.
  task automatic run_phase(input int quota);
    int stop;
    int roll;
    stop = n_issued + quota;
    while (n_issued < stop) begin
      roll = $urandom_range(99);
      if (roll < 45) chain_lifecycle();
      else if (roll < 60 && lim_now > 2) ring_walk();
      else send_req(pick_kind(), pick_cluster(), pick_value(), pick_count());
    end
    settle();
  endtask

  // Main sequence: reset, table clear, directed cases, then random phases.
  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= CFG_ENTRIES;
    cfg_wdata      <= '0;
    req_ch.valid   <= 1'b0;
    req_ch.kind    <= KIND_LOAD;
    req_ch.cluster <= '0;
    req_ch.value   <= '0;
    req_ch.count   <= '0;
    lim_now        = TABLE_DEPTH;
    guard_now      = int'(CLIM_RST) + int'(GUARD_EXTRA);
    walk_cap       = 40;
    calm           = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Narrow the table to the cleared entries; each of them is written before any read.
    set_phase(CLEAR_N, int'(CLIM_RST), 1'b0);
    for (int i = 0; i < CLEAR_N; i++) begin
      send_req(KIND_LOAD, DATA_W'(i), CODE_FREE, DATA_W'($urandom));
    end

    // Directed cases at the default loop guard.
    send_req(KIND_READ, 16'd0, '0, '0);
    send_req(KIND_READ, DATA_W'(CLEAR_N - 1), '0, '0);
    send_req(KIND_READ, DATA_W'(CLEAR_N), '0, '0);
    send_req(KIND_LOAD, 16'hFFFF, 16'hA5A5, '0);
    send_req(KIND_LOAD, DATA_W'(CLEAR_N - 1), 16'hFFFF, '0);
    send_req(KIND_ALLOC, '0, '0, 16'd0);
    send_req(KIND_ALLOC, '0, '0, 16'hFFFF);
    send_req(KIND_ALLOC, '0, '0, 16'd3);
    send_req(KIND_NEXT, 16'd2, '0, '0);
    send_req(KIND_NEXT, 16'd3, '0, '0);
    send_req(KIND_NEXT, 16'd4, '0, '0);
    send_req(KIND_NEXT, 16'd1, '0, '0);
    send_req(KIND_NEXT, 16'hFFFF, '0, '0);
    send_req(KIND_LOAD, 16'd10, CODE_BAD, '0);
    send_req(KIND_NEXT, 16'd10, '0, '0);
    send_req(KIND_LOAD, 16'd11, 16'd1, '0);
    send_req(KIND_NEXT, 16'd11, '0, '0);
    send_req(KIND_NEXT, 16'd12, '0, '0);
    send_req(KIND_FREE, 16'd2, '0, '0);
    send_req(KIND_FREE, 16'd10, '0, '0);
    send_req(KIND_FREE, 16'd1, '0, '0);
    send_req(KIND_FREE, CODE_END_MIN, '0, '0);
    for (int k = int'(KIND_BAD_FIRST); k <= int'(KIND_BAD_LAST); k++) begin
      send_req(KIND_W'(k), 16'hFFFF, 16'hFFFF, 16'hFFFF);
    end
    settle();

    // Entry count above the table depth: the depth bounds the range, only written
    // entries are touched.
    set_phase((1 << EIU_W) - 1, int'(CLIM_RST), 1'b0);
    send_req(KIND_READ, DATA_W'(TABLE_DEPTH), '0, '0);
    send_req(KIND_LOAD, DATA_W'(TABLE_DEPTH), 16'h1234, '0);
    send_req(KIND_READ, 16'd5, '0, '0);
    send_req(KIND_NEXT, DATA_W'(TABLE_DEPTH + 7), '0, '0);
    send_req(KIND_NEXT, 16'hFFFF, '0, '0);
    settle();

    // Random phases over several register settings, the extremes among them.
    set_phase(200, 65535, 1'b0);
    run_phase(150);
    set_phase(2, 0, 1'b0);
    run_phase(30);
    set_phase(16, 0, 1'b0);
    run_phase(200);
    set_phase(64, 3, 1'b1);
    run_phase(250);
    set_phase(37, 20, 1'b0);
    run_phase(200);
    set_phase(CLEAR_N, int'(CLIM_RST), 1'b0);
    run_phase(150);
    set_phase(CLEAR_N, 10, 1'b0);
    run_phase(100);
    set_phase(3, 1, 1'b0);
    run_phase(40);

    settle();
    repeat (20) @(posedge clk);
    $display("Run covered %0d requests (load %0d, read %0d, allocate %0d, free %0d, next %0d,",
             n_issued, kind_hits[KIND_LOAD], kind_hits[KIND_READ], kind_hits[KIND_ALLOC],
             kind_hits[KIND_FREE], kind_hits[KIND_NEXT]);
    $display("  unknown %0d) over %0d register settings; results ok %0d, no space %0d,",
             kind_hits[5] + kind_hits[6] + kind_hits[7], n_settings,
             status_hits[ST_OK], status_hits[ST_NOSPACE]);
    $display("  end %0d, free %0d, bad %0d, range %0d, loop %0d.",
             status_hits[ST_END], status_hits[ST_FREE], status_hits[ST_BAD],
             status_hits[ST_RANGE], status_hits[ST_LOOP]);
    if (fails == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d failures, %0d results never arrived.", fails, outstanding);
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #250_000_000;
    $display("Timeout with %0d results outstanding.", n_sent - n_done);
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fcce_pkg.sv
rtl/fcce_req_if.sv
rtl/fcce_rsp_if.sv
rtl/fcce_ram.sv
rtl/fat16_cluster_chain_engine_core.sv
rtl/fcce_chk.sv
dv/fcce_chain_checker.sv
dv/tb.sv
